// ===== rtl/btd_pkg.sv =====
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types and constants of the BER TLV decoder: element kinds, tag
// values, status codes, decode phases and the result record.
// ----------------------------------------------------------------------------
package btd_pkg;

  // Expected element kind, sampled from mode on the tag byte
  localparam logic [1:0] MODE_INTEGER = 2'd0;
  localparam logic [1:0] MODE_OCTETS  = 2'd1;
  localparam logic [1:0] MODE_OID     = 2'd2;

  // Universal tags
  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] TAG_OCTETS  = 8'h04;
  localparam logic [7:0] TAG_OID     = 8'h06;

  // Length head fields
  localparam logic [7:0] LEN_LONG_BIT  = 8'h80;
  localparam logic [7:0] LEN_COUNT_MSK = 8'h7F;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WRONG_TAG = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_EMPTY_INT = 3'd4;

  // Configuration register indexes and reset value
  localparam logic       REG_COPY_LIMIT   = 1'b0;
  localparam logic [15:0] COPY_LIMIT_RESET = 16'd64;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LHEAD = 4'b0010,
    PH_LEXT  = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        content_valid;
    logic [7:0]  content_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] int_value;
    logic [15:0] content_length;
    logic [15:0] copied_count;
    logic [16:0] consumed_bytes;
  } res_t;

endpackage

// ===== rtl/ber_tlv_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_decoder_unit
// Streaming ASN.1 BER TLV decoder for INTEGER, OCTET STRING and OBJECT
// IDENTIFIER elements, one encoded byte per beat.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------
//  s_*     | in  | tdata: data_byte; tuser: tlv_start, mode; tlast: end_of_buffer
//  m_*     | out | tdata: content/status/int/lengths; tuser: content_valid;
//          |     | tlast: done_res
//  APB     | in  | copy_limit at byte address 0
//
// The element state and the output register both load at the edge that
// accepts the beat, so a result shows on m_* in the cycle right after its
// byte is taken.
// Sustained rate is one byte per cycle; the only limit is the output register.
// s_tready drops only while a result waits in the output register and the
// downstream side holds m_tready low.
// Reset (rst, synchronous) returns to idle, empties the output register and
// sets copy_limit to 64.
// ----------------------------------------------------------------------------
module ber_tlv_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_tuser,   // [0] tlv_start, [2:1] mode
  input  logic        s_tlast,   // end_of_buffer
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [7:0] content_byte, [10:8] status,
                                 // [42:11] int_value, [58:43] content_length,
                                 // [74:59] copied_count, [91:75] consumed_bytes,
                                 // [95:92] zero
  output logic        m_tuser,   // content_valid
  output logic        m_tlast,   // done_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          accept;
  logic          res_valid;
  btd_pkg::res_t res;
  btd_pkg::res_t out_res;
  logic          out_valid;
  logic [15:0]   copy_limit;

  // Register file: one register, write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == btd_pkg::REG_COPY_LIMIT) ? {16'd0, copy_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_limit <= btd_pkg::COPY_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == btd_pkg::REG_COPY_LIMIT) begin
      copy_limit <= pwdata[15:0];
    end
  end

  // Take a new byte whenever the output register is free or being drained
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  btd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .tlv_start     (s_tuser[0]),
    .end_of_buffer (s_tlast),
    .mode          (s_tuser[2:1]),
    .copy_limit    (copy_limit),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register: load on a result, drop once the downstream takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.content_valid;
  assign m_tlast  = out_res.done_res;
  assign m_tdata  = {4'd0, out_res.consumed_bytes, out_res.copied_count,
                     out_res.content_length, out_res.int_value, out_res.status,
                     out_res.content_byte};

  // A content beat that does not close the element always carries a byte
  a_content_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser && m_tdata[10:8] == btd_pkg::ST_OK)
    else $error("content beat without byte or with status");

  // A failed element hands out no byte on its closing beat
  a_error_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tdata[10:8] != btd_pkg::ST_OK |-> !m_tuser)
    else $error("error result carries a content byte");

  // Copied count never exceeds the length field
  a_copied_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[74:59] <= m_tdata[58:43])
    else $error("copied count above content length");

  // Integers never report copied bytes and strings never an integer value
  a_int_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[74:59] == 16'd0 || m_tdata[42:11] == 32'd0)
    else $error("both integer value and copied count set");

  // The output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result pending after reset");

endmodule

// ===== rtl/btd_core.sv =====
// ----------------------------------------------------------------------------
// btd_core
// Element state of the decoder and the one-byte step: updates the state on
// each accepted beat and forms the result of that beat, if any.
// ----------------------------------------------------------------------------
module btd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               tlv_start,
  input  logic               end_of_buffer,
  input  logic [1:0]         mode,
  input  logic [15:0]        copy_limit,
  output logic               res_valid,
  output btd_pkg::res_t      res
);

  btd_pkg::phase_t phase, phase_next;
  logic [1:0]  element_type, element_type_next;
  logic [1:0]  length_bytes_left, length_bytes_left_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] content_seen, content_seen_next;
  logic [31:0] accumulator, accumulator_next;
  logic [16:0] byte_total, byte_total_next;

  logic        fin;
  logic [2:0]  fin_status;
  logic        cv;
  logic        emit;
  logic        enter;
  logic [7:0]  tag;
  logic        tag_ok;
  logic [6:0]  len_count;
  logic [15:0] min_len;

  always_comb begin
    phase_next             = phase;
    element_type_next      = element_type;
    length_bytes_left_next = length_bytes_left;
    length_value_next      = length_value;
    content_seen_next      = content_seen;
    accumulator_next       = accumulator;
    byte_total_next        = byte_total;
    fin        = 1'b0;
    fin_status = btd_pkg::ST_OK;
    cv         = 1'b0;
    emit       = 1'b0;
    enter      = 1'b0;
    len_count  = data_byte[6:0] & btd_pkg::LEN_COUNT_MSK[6:0];
    tag        = btd_pkg::TAG_INTEGER;
    tag_ok     = 1'b0;

    case (mode)
      btd_pkg::MODE_INTEGER: begin tag = btd_pkg::TAG_INTEGER; tag_ok = 1'b1; end
      btd_pkg::MODE_OCTETS:  begin tag = btd_pkg::TAG_OCTETS;  tag_ok = 1'b1; end
      btd_pkg::MODE_OID:     begin tag = btd_pkg::TAG_OID;     tag_ok = 1'b1; end
      default:               begin tag = btd_pkg::TAG_INTEGER; tag_ok = 1'b0; end
    endcase

    if (tlv_start) begin
      element_type_next      = mode;
      length_bytes_left_next = 2'd0;
      length_value_next      = 16'd0;
      content_seen_next      = 16'd0;
      accumulator_next       = 32'd0;
      byte_total_next        = 17'd1;
      if (!tag_ok || data_byte != tag) begin
        fin = 1'b1; fin_status = btd_pkg::ST_WRONG_TAG;
      end else if (end_of_buffer) begin
        fin = 1'b1; fin_status = btd_pkg::ST_TRUNC;
      end else begin
        phase_next = btd_pkg::PH_LHEAD;
      end
    end else begin
      case (phase)
        btd_pkg::PH_IDLE: begin
        end
        btd_pkg::PH_LHEAD: begin
          byte_total_next = byte_total + 17'd1;
          if ((data_byte & btd_pkg::LEN_LONG_BIT) == 8'd0) begin
            length_value_next = {8'd0, data_byte};
            enter = 1'b1;
          end else if (len_count != 7'd1 && len_count != 7'd2) begin
            fin = 1'b1; fin_status = btd_pkg::ST_BAD_LEN;
          end else if (end_of_buffer) begin
            fin = 1'b1; fin_status = btd_pkg::ST_TRUNC;
          end else begin
            length_bytes_left_next = len_count[1:0];
            phase_next = btd_pkg::PH_LEXT;
          end
        end
        btd_pkg::PH_LEXT: begin
          byte_total_next        = byte_total + 17'd1;
          length_value_next      = {length_value[7:0], data_byte};
          length_bytes_left_next = length_bytes_left - 2'd1;
          if (end_of_buffer) begin
            fin = 1'b1; fin_status = btd_pkg::ST_TRUNC;
          end else if (length_bytes_left_next == 2'd0) begin
            enter = 1'b1;
          end
        end
        btd_pkg::PH_BODY: begin
          byte_total_next = byte_total + 17'd1;
          if (element_type == btd_pkg::MODE_INTEGER) begin
            if (content_seen == 16'd0) begin
              accumulator_next = {{24{data_byte[7]}}, data_byte};
            end else begin
              accumulator_next = {accumulator[23:0], data_byte};
            end
          end
          content_seen_next = content_seen + 16'd1;
          cv = (element_type != btd_pkg::MODE_INTEGER) && (content_seen < copy_limit);
          if (content_seen_next == length_value) begin
            fin = 1'b1; fin_status = btd_pkg::ST_OK;
          end else if (end_of_buffer) begin
            fin = 1'b1; fin_status = btd_pkg::ST_TRUNC; cv = 1'b0;
          end else begin
            emit = cv;
          end
        end
        default: begin
          phase_next = btd_pkg::PH_IDLE;
        end
      endcase
    end

    // Move from the length field into the content
    if (enter) begin
      if (length_value_next == 16'd0) begin
        fin = 1'b1;
        fin_status = (element_type_next == btd_pkg::MODE_INTEGER) ?
                     btd_pkg::ST_EMPTY_INT : btd_pkg::ST_OK;
      end else if (end_of_buffer) begin
        fin = 1'b1; fin_status = btd_pkg::ST_TRUNC;
      end else begin
        content_seen_next = 16'd0;
        phase_next = btd_pkg::PH_BODY;
      end
    end

    if (fin) begin
      phase_next = btd_pkg::PH_IDLE;
    end
  end

  assign min_len = (length_value_next < copy_limit) ? length_value_next : copy_limit;

  always_comb begin
    res_valid          = accept && (fin || emit);
    res.content_valid  = cv && (fin || emit);
    res.content_byte   = (cv && (fin || emit)) ? data_byte : 8'd0;
    res.done_res       = fin;
    res.status         = fin ? fin_status : btd_pkg::ST_OK;
    res.content_length = length_value_next;
    res.consumed_bytes = byte_total_next;
    res.int_value      = 32'd0;
    res.copied_count   = 16'd0;
    if (fin && fin_status == btd_pkg::ST_OK) begin
      if (element_type_next == btd_pkg::MODE_INTEGER) begin
        res.int_value = accumulator_next;
      end else begin
        res.copied_count = min_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= btd_pkg::PH_IDLE;
      element_type      <= 2'd0;
      length_bytes_left <= 2'd0;
      length_value      <= 16'd0;
      content_seen      <= 16'd0;
      accumulator       <= 32'd0;
      byte_total        <= 17'd0;
    end else if (accept) begin
      phase             <= phase_next;
      element_type      <= element_type_next;
      length_bytes_left <= length_bytes_left_next;
      length_value      <= length_value_next;
      content_seen      <= content_seen_next;
      accumulator       <= accumulator_next;
      byte_total        <= byte_total_next;
    end
  end

endmodule
